// ===== sv/blad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blad_pkg
// Types and codes shared by the bounded list core and its storage cells.
// ----------------------------------------------------------------------------
package blad_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned CAP_W    = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LIST   = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_NOMATCH = 2'd3
    } status_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic signed [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  element;
        logic                       last;
        logic [COUNT_W-1:0]         entry_count;
    } rsp_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    // Command broadcast to every cell in the chain
    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

endpackage

// ===== sv/bounded_list_append_delete_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_append_delete_core
// Ordered list of signed 32-bit entries held in a chain of cells: append,
// delete first match, clear, and list all.
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  --------+-----------------------------+-------------------------------
//  req     | req_valid / req_stall       | req_t  (kind, value)
//  rsp     | rsp_valid / rsp_stall       | rsp_t  (status, element, last,
//          |                             |         entry_count)
//  cfg     | cfg_we                      | cfg_wdata (capacity limit)
//
//  Append, delete and clear register their result at the accept edge, and
//  the next request can go in on the following edge unless rsp stalls.
//  List spends the accept cycle starting the walk, then walks the entries:
//  the chain rotates by one slot per result and the head cell feeds the
//  output register; new requests wait until the last entry is registered.
//  Delete compares all cells at once and closes the gap in the same cycle.
//  Reset empties the list and sets the capacity to 16; entries are not reset.
//  A stalled response holds in the output register and stalls req.
// ----------------------------------------------------------------------------
module bounded_list_append_delete_core
    import blad_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned XW = (CW > CAP_W) ? CW : CAP_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CAP_W-1:0]  cap_reg;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    cell_cmd_t                  cmd;
    logic                       out_free;
    logic                       full;
    logic                       list_last;
    logic                       found;
    logic [MAX_ENTRIES-1:0]     at_tail;
    logic [MAX_ENTRIES-1:0]     in_range;
    logic [MAX_ENTRIES:0]       seen;
    logic signed [VALUE_W-1:0]  cell_data [MAX_ENTRIES];

    // ---- cell chain ----
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] nbr_data;

        if (i == MAX_ENTRIES - 1)
        begin : g_end
            assign nbr_data = cell_data[i];
        end
        else
        begin : g_mid
            assign nbr_data = cell_data[i+1];
        end

        assign in_range[i] = CW'(i) < count_reg;
        // append writes the first free slot; rotation wraps into the last used one
        assign at_tail[i]  = (state_reg == S_LIST) ? (CW'(i) == count_reg - CW'(1))
                                                   : (CW'(i) == count_reg);

        blad_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .at_tail   (at_tail[i]),
            .in_range  (in_range[i]),
            .next_data (nbr_data),
            .head_data (cell_data[0]),
            .seen_in   (seen[i]),
            .seen_out  (seen[i+1]),
            .data      (cell_data[i])
        );
    end

    assign found = seen[MAX_ENTRIES];

    // ---- control ----
    assign full      = (XW'(count_reg) >= XW'(cap_reg)) || (count_reg == CW'(MAX_ENTRIES));
    assign list_last = (idx_reg + CW'(1)) == count_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd.op         = CELL_HOLD;
        cmd.value      = req.value;
        req_stall      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                req_stall = !out_free;
                if (req_valid && out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = STAT_DONE;
                    rsp_next.element = '0;
                    rsp_next.last    = 1'b1;
                    case (req.kind)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op     = CELL_APPEND;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            cmd.op = CELL_DELETE;
                            if (found)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                rsp_next.status = STAT_NOMATCH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                // results come from the list walk
                                rsp_valid_next = 1'b0;
                                state_next     = S_LIST;
                                idx_next       = '0;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_DONE;
                        end
                    endcase
                    rsp_next.entry_count = COUNT_W'(count_next);
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = STAT_DONE;
                    rsp_next.element     = cell_data[0];
                    rsp_next.last        = list_last;
                    rsp_next.entry_count = COUNT_W'(count_reg);
                    cmd.op               = CELL_ROTATE;
                    idx_next             = idx_reg + CW'(1);
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= XW'(MAX_ENTRIES))
        else $error("entry count above list depth");

    a_list_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> req_stall)
        else $error("request taken during list walk");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.kind == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries behind");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == STAT_EMPTY) |-> (rsp.entry_count == '0 && rsp.last))
        else $error("empty status on non-empty list");

    a_list_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST && $past(state_reg) == S_LIST) |-> $stable(count_reg))
        else $error("entry count changed during list walk");

endmodule

// ===== sv/blad_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blad_cell
// One list slot: holds an entry, compares it against the delete key and
// takes its neighbor's entry when the list closes a gap or rotates.
// ----------------------------------------------------------------------------
module blad_cell
    import blad_pkg::*;
(
    input  logic                       clk,
    input  cell_cmd_t                  cmd,
    input  logic                       at_tail,
    input  logic                       in_range,
    input  logic signed [VALUE_W-1:0]  next_data,
    input  logic signed [VALUE_W-1:0]  head_data,
    input  logic                       seen_in,
    output logic                       seen_out,
    output logic signed [VALUE_W-1:0]  data
);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic                      match;

    assign match    = in_range && (data_reg == cmd.value);
    // first match at or before this slot: this slot and all later ones shift down
    assign seen_out = seen_in || match;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_APPEND:
            begin
                if (at_tail)
                begin
                    data_next = cmd.value;
                end
            end
            CELL_DELETE:
            begin
                if (seen_out)
                begin
                    data_next = next_data;
                end
            end
            CELL_ROTATE:
            begin
                if (at_tail)
                begin
                    data_next = head_data;
                end
                else if (in_range)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
